// ===== design/rtnh_pkg.sv =====
`timescale 1ns / 1ps

package rtnh_pkg;

    // Fixed field widths of the payload.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ID_WIDTH    = 16;
    localparam int DIST_WIDTH  = COORD_WIDTH - 1;

    // Exact widths of the intermediate values.
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int DOT_W   = DIFF_W + CROSS_W + 2;
    localparam int NUM_W   = DOT_W + FRAC_BITS;

    // Digit-serial multiplier: the narrow operand is taken DIG bits a cycle.
    localparam int DIG       = 16;
    localparam int NDIG      = (DIFF_W + DIG - 1) / DIG;
    localparam int DIG_IDX_W = $clog2(NDIG);
    localparam int STEP_W    = $clog2(NDIG + 2);
    localparam int PP_W      = CROSS_W + DIG + 1;

    // Multiply-accumulate programme and divider.
    localparam int NOPS  = 24;
    localparam int OP_W  = $clog2(NOPS);
    localparam int CNT_W = $clog2(DIST_WIDTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_a_z;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_z;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_z;
        logic [ID_WIDTH-1:0]           owner_id;
        logic                          last_triangle;
    } tri_t;

    typedef struct packed {
        logic                  hit_found;
        logic [ID_WIDTH-1:0]   nearest_owner;
        logic [DIST_WIDTH-1:0] nearest_distance;
    } pick_t;

    // Operand sources of the multiplier.
    typedef enum logic [2:0] {A_DIR, A_E1, A_E2, A_TV, A_P, A_Q} a_src_t;
    typedef enum logic [1:0] {B_DIR, B_E1, B_E2, B_TV} b_src_t;
    typedef enum logic [3:0] {
        D_NONE, D_P0, D_P1, D_P2, D_Q0, D_Q1, D_Q2, D_DET, D_SU, D_SV, D_ST
    } dest_t;

    typedef struct packed {
        a_src_t     a_sel;
        logic [1:0] a_comp;
        b_src_t     b_sel;
        logic [1:0] b_comp;
        logic       neg;
        logic       first;
        dest_t      dest;
    } op_t;

    typedef struct packed {
        logic              load;
        logic              mac_en;
        op_t               op;
        logic [STEP_W-1:0] step;
        logic              fix;
        logic              test;
        logic              div_init;
        logic              div_step;
        logic [CNT_W-1:0]  div_idx;
        logic              update;
        logic              report;
    } rtnh_cmd_t;

    typedef struct packed {
        logic last;
        logic hit;
        logic out_busy;
    } rtnh_status_t;

    function automatic op_t mk_op(input a_src_t a, input logic [1:0] ac, input b_src_t b,
                                  input logic [1:0] bc, input logic neg, input logic first,
                                  input dest_t dest);
        op_t o;
        o.a_sel  = a;
        o.a_comp = ac;
        o.b_sel  = b;
        o.b_comp = bc;
        o.neg    = neg;
        o.first  = first;
        o.dest   = dest;
        return o;
    endfunction

    // Programme: p = D x e2, det = e1.p, q = T x e1, su = T.p, sv = D.q, st = e2.q.
    function automatic op_t op_table(input logic [OP_W-1:0] idx);
        op_t o;
        unique case (idx)
            5'd0:    o = mk_op(A_DIR, 2'd1, B_E2,  2'd2, 1'b0, 1'b1, D_NONE);
            5'd1:    o = mk_op(A_DIR, 2'd2, B_E2,  2'd1, 1'b1, 1'b0, D_P0);
            5'd2:    o = mk_op(A_DIR, 2'd2, B_E2,  2'd0, 1'b0, 1'b1, D_NONE);
            5'd3:    o = mk_op(A_DIR, 2'd0, B_E2,  2'd2, 1'b1, 1'b0, D_P1);
            5'd4:    o = mk_op(A_DIR, 2'd0, B_E2,  2'd1, 1'b0, 1'b1, D_NONE);
            5'd5:    o = mk_op(A_DIR, 2'd1, B_E2,  2'd0, 1'b1, 1'b0, D_P2);
            5'd6:    o = mk_op(A_P,   2'd0, B_E1,  2'd0, 1'b0, 1'b1, D_NONE);
            5'd7:    o = mk_op(A_P,   2'd1, B_E1,  2'd1, 1'b0, 1'b0, D_NONE);
            5'd8:    o = mk_op(A_P,   2'd2, B_E1,  2'd2, 1'b0, 1'b0, D_DET);
            5'd9:    o = mk_op(A_TV,  2'd1, B_E1,  2'd2, 1'b0, 1'b1, D_NONE);
            5'd10:   o = mk_op(A_TV,  2'd2, B_E1,  2'd1, 1'b1, 1'b0, D_Q0);
            5'd11:   o = mk_op(A_TV,  2'd2, B_E1,  2'd0, 1'b0, 1'b1, D_NONE);
            5'd12:   o = mk_op(A_TV,  2'd0, B_E1,  2'd2, 1'b1, 1'b0, D_Q1);
            5'd13:   o = mk_op(A_TV,  2'd0, B_E1,  2'd1, 1'b0, 1'b1, D_NONE);
            5'd14:   o = mk_op(A_TV,  2'd1, B_E1,  2'd0, 1'b1, 1'b0, D_Q2);
            5'd15:   o = mk_op(A_P,   2'd0, B_TV,  2'd0, 1'b0, 1'b1, D_NONE);
            5'd16:   o = mk_op(A_P,   2'd1, B_TV,  2'd1, 1'b0, 1'b0, D_NONE);
            5'd17:   o = mk_op(A_P,   2'd2, B_TV,  2'd2, 1'b0, 1'b0, D_SU);
            5'd18:   o = mk_op(A_Q,   2'd0, B_DIR, 2'd0, 1'b0, 1'b1, D_NONE);
            5'd19:   o = mk_op(A_Q,   2'd1, B_DIR, 2'd1, 1'b0, 1'b0, D_NONE);
            5'd20:   o = mk_op(A_Q,   2'd2, B_DIR, 2'd2, 1'b0, 1'b0, D_SV);
            5'd21:   o = mk_op(A_Q,   2'd0, B_E2,  2'd0, 1'b0, 1'b1, D_NONE);
            5'd22:   o = mk_op(A_Q,   2'd1, B_E2,  2'd1, 1'b0, 1'b0, D_NONE);
            5'd23:   o = mk_op(A_Q,   2'd2, B_E2,  2'd2, 1'b0, 1'b0, D_ST);
            default: o = mk_op(A_DIR, 2'd0, B_DIR, 2'd0, 1'b0, 1'b1, D_NONE);
        endcase
        return o;
    endfunction

endpackage

// ===== design/rtnh_controller.sv =====
`timescale 1ns / 1ps

module rtnh_controller import rtnh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  rtnh_status_t status,
    output rtnh_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_MAC     = 8'b0000_0010,
        S_FIX     = 8'b0000_0100,
        S_TEST    = 8'b0000_1000,
        S_DIVINIT = 8'b0001_0000,
        S_DIV     = 8'b0010_0000,
        S_UPDATE  = 8'b0100_0000,
        S_REPORT  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Sequencing of the multiply programme, the divider and the result.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        cmd          = '0;
        cmd.op       = op_table(op_reg);
        cmd.step     = step_reg;
        cmd.div_idx  = cnt_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_MAC;
                    op_next    = '0;
                    step_next  = '0;
                end
            end
            S_MAC: begin
                cmd.mac_en = 1'b1;
                if (step_reg == STEP_W'(NDIG + 1)) begin
                    step_next = '0;
                    if (op_reg == OP_W'(NOPS - 1)) begin
                        state_next = S_FIX;
                    end else begin
                        op_next = op_reg + 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_FIX: begin
                cmd.fix    = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                cmd.test   = 1'b1;
                state_next = S_DIVINIT;
            end
            S_DIVINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = CNT_W'(DIST_WIDTH - 1);
                state_next   = status.hit ? S_DIV : S_UPDATE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_UPDATE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.last ? S_REPORT : S_IDLE;
            end
            S_REPORT: begin
                if (!status.out_busy) begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/rtnh_datapath.sv =====
`timescale 1ns / 1ps

module rtnh_datapath import rtnh_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tri_t                   s_data,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  rtnh_cmd_t              cmd,
    output rtnh_status_t           status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pick_t                  m_data
);

    logic signed [COORD_WIDTH-1:0] org_reg [3];
    logic signed [COORD_WIDTH-1:0] dir_reg [3];
    logic signed [DIFF_W-1:0]      e1_reg [3];
    logic signed [DIFF_W-1:0]      e2_reg [3];
    logic signed [DIFF_W-1:0]      tv_reg [3];
    logic signed [CROSS_W-1:0]     p_reg [3];
    logic signed [CROSS_W-1:0]     q_reg [3];
    logic signed [DOT_W-1:0]       det_reg, su_reg, sv_reg, st_reg;
    logic signed [DOT_W-1:0]       acc_reg, acc_next, prod_reg, term;
    logic signed [PP_W-1:0]        pp_reg, pp_full;
    logic [ID_WIDTH-1:0]           owner_reg, best_owner_reg;
    logic [DIST_WIDTH-1:0]         best_reg, quot_reg, hit_dist;
    logic                          last_reg, hit_reg, sat_reg, any_reg, out_valid_reg;
    logic [NUM_W-1:0]              num_reg, rem0;
    logic [DOT_W:0]                rem_reg, rem_sh, sum_uv;
    logic [DIST_WIDTH-1:0]         num_lo;
    logic [DOT_W-1:0]              st_abs;
    logic                          rem_ge, in_tri;
    pick_t                         out_reg;

    logic signed [CROSS_W-1:0]     a_val;
    logic signed [DIFF_W-1:0]      b_val;
    logic signed [NDIG*DIG-1:0]    b_pad;
    logic [DIG_IDX_W-1:0]          dig_idx;
    logic [DIG-1:0]                digit;
    logic signed [DIG:0]           dig_s;
    logic signed [COORD_WIDTH-1:0] va [3];
    logic signed [COORD_WIDTH-1:0] vb [3];
    logic signed [COORD_WIDTH-1:0] vc [3];

    function automatic logic signed [CROSS_W-1:0] sel_a(
        input logic signed [CROSS_W-1:0] x0, input logic signed [CROSS_W-1:0] x1,
        input logic signed [CROSS_W-1:0] x2, input logic [1:0] s);
        logic signed [CROSS_W-1:0] r;
        unique case (s)
            2'd0:    r = x0;
            2'd1:    r = x1;
            default: r = x2;
        endcase
        return r;
    endfunction

    function automatic logic signed [DIFF_W-1:0] sel_b(
        input logic signed [DIFF_W-1:0] x0, input logic signed [DIFF_W-1:0] x1,
        input logic signed [DIFF_W-1:0] x2, input logic [1:0] s);
        logic signed [DIFF_W-1:0] r;
        unique case (s)
            2'd0:    r = x0;
            2'd1:    r = x1;
            default: r = x2;
        endcase
        return r;
    endfunction

    assign va[0] = s_data.vertex_a_x;
    assign va[1] = s_data.vertex_a_y;
    assign va[2] = s_data.vertex_a_z;
    assign vb[0] = s_data.vertex_b_x;
    assign vb[1] = s_data.vertex_b_y;
    assign vb[2] = s_data.vertex_b_z;
    assign vc[0] = s_data.vertex_c_x;
    assign vc[1] = s_data.vertex_c_y;
    assign vc[2] = s_data.vertex_c_z;

    // Ray registers, written through the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
            dir_reg[2] <= COORD_WIDTH'(1 << FRAC_BITS);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                CFG_DIR_X:    dir_reg[0] <= cfg_data;
                CFG_DIR_Y:    dir_reg[1] <= cfg_data;
                CFG_DIR_Z:    dir_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Edge and offset vectors are formed when the triangle is taken in.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= DIFF_W'(vb[i]) - DIFF_W'(va[i]);
                e2_reg[i] <= DIFF_W'(vc[i]) - DIFF_W'(va[i]);
                tv_reg[i] <= DIFF_W'(org_reg[i]) - DIFF_W'(va[i]);
            end
            owner_reg <= s_data.owner_id;
            last_reg  <= s_data.last_triangle;
        end
    end

    // Operand selection for the multiplier.
    always_comb begin
        unique case (cmd.op.a_sel)
            A_DIR:   a_val = sel_a(CROSS_W'(dir_reg[0]), CROSS_W'(dir_reg[1]),
                                   CROSS_W'(dir_reg[2]), cmd.op.a_comp);
            A_E1:    a_val = sel_a(CROSS_W'(e1_reg[0]), CROSS_W'(e1_reg[1]),
                                   CROSS_W'(e1_reg[2]), cmd.op.a_comp);
            A_E2:    a_val = sel_a(CROSS_W'(e2_reg[0]), CROSS_W'(e2_reg[1]),
                                   CROSS_W'(e2_reg[2]), cmd.op.a_comp);
            A_TV:    a_val = sel_a(CROSS_W'(tv_reg[0]), CROSS_W'(tv_reg[1]),
                                   CROSS_W'(tv_reg[2]), cmd.op.a_comp);
            A_P:     a_val = sel_a(p_reg[0], p_reg[1], p_reg[2], cmd.op.a_comp);
            default: a_val = sel_a(q_reg[0], q_reg[1], q_reg[2], cmd.op.a_comp);
        endcase
        unique case (cmd.op.b_sel)
            B_DIR:   b_val = sel_b(DIFF_W'(dir_reg[0]), DIFF_W'(dir_reg[1]),
                                   DIFF_W'(dir_reg[2]), cmd.op.b_comp);
            B_E1:    b_val = sel_b(e1_reg[0], e1_reg[1], e1_reg[2], cmd.op.b_comp);
            B_E2:    b_val = sel_b(e2_reg[0], e2_reg[1], e2_reg[2], cmd.op.b_comp);
            default: b_val = sel_b(tv_reg[0], tv_reg[1], tv_reg[2], cmd.op.b_comp);
        endcase
    end

    // One digit of the narrow operand, most significant first; only the top digit is signed.
    assign b_pad   = (NDIG * DIG)'(b_val);
    assign dig_idx = DIG_IDX_W'(NDIG - 1) - DIG_IDX_W'(cmd.step);
    assign digit   = b_pad[dig_idx * DIG +: DIG];
    assign dig_s   = (dig_idx == DIG_IDX_W'(NDIG - 1)) ? {digit[DIG-1], digit}
                                                       : {1'b0, digit};
    assign pp_full = PP_W'(a_val) * PP_W'(dig_s);

    // Accumulated term, signed as the operation asks.
    assign term     = cmd.op.neg ? -prod_reg : prod_reg;
    assign acc_next = (cmd.op.first ? '0 : acc_reg) + term;

    // Multiply-accumulate: partial product, shift-add, then accumulate and store.
    always_ff @(posedge aclk) begin
        if (cmd.mac_en) begin
            if (cmd.step < STEP_W'(NDIG)) begin
                pp_reg <= pp_full;
            end
            if (cmd.step >= STEP_W'(1) && cmd.step <= STEP_W'(NDIG)) begin
                prod_reg <= ((cmd.step == STEP_W'(1)) ? '0 : (prod_reg <<< DIG))
                            + DOT_W'(pp_reg);
            end
            if (cmd.step == STEP_W'(NDIG + 1)) begin
                acc_reg <= acc_next;
                unique case (cmd.op.dest)
                    D_P0:    p_reg[0] <= acc_next[CROSS_W-1:0];
                    D_P1:    p_reg[1] <= acc_next[CROSS_W-1:0];
                    D_P2:    p_reg[2] <= acc_next[CROSS_W-1:0];
                    D_Q0:    q_reg[0] <= acc_next[CROSS_W-1:0];
                    D_Q1:    q_reg[1] <= acc_next[CROSS_W-1:0];
                    D_Q2:    q_reg[2] <= acc_next[CROSS_W-1:0];
                    D_DET:   det_reg  <= acc_next;
                    D_SU:    su_reg   <= acc_next;
                    D_SV:    sv_reg   <= acc_next;
                    D_ST:    st_reg   <= acc_next;
                    default: ;
                endcase
            end
        end else if (cmd.fix && det_reg[DOT_W-1]) begin
            // Make the determinant positive and flip the other sums with it.
            det_reg <= -det_reg;
            su_reg  <= -su_reg;
            sv_reg  <= -sv_reg;
            st_reg  <= -st_reg;
        end
    end

    // Inside test and numerator of the distance.
    assign sum_uv = {1'b0, su_reg} + {1'b0, sv_reg};
    assign in_tri = (det_reg != '0) && !su_reg[DOT_W-1] && !sv_reg[DOT_W-1]
                    && (sum_uv < {1'b0, det_reg});
    assign st_abs = st_reg[DOT_W-1] ? DOT_W'(-st_reg) : DOT_W'(st_reg);

    // Restoring divider, one quotient bit a cycle.
    assign rem0   = num_reg >> DIST_WIDTH;
    assign num_lo = num_reg[DIST_WIDTH-1:0];
    assign rem_sh = {rem_reg[DOT_W-1:0], num_lo[cmd.div_idx]};
    assign rem_ge = rem_sh >= {1'b0, det_reg};

    always_ff @(posedge aclk) begin
        if (cmd.test) begin
            num_reg <= {st_abs, {FRAC_BITS{1'b0}}};
        end
        if (cmd.div_init) begin
            sat_reg  <= rem0 >= NUM_W'(det_reg);
            rem_reg  <= rem0[DOT_W:0];
            quot_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sh - {1'b0, det_reg} : rem_sh;
            quot_reg[cmd.div_idx] <= rem_ge;
        end
    end

    assign hit_dist = sat_reg ? '1 : quot_reg;

    // Search state, result register and hit flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            any_reg        <= 1'b0;
            best_reg       <= '1;
            best_owner_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.test) begin
                hit_reg <= in_tri;
            end
            if (cmd.update && hit_reg && (!any_reg || hit_dist < best_reg)) begin
                any_reg        <= 1'b1;
                best_reg       <= hit_dist;
                best_owner_reg <= owner_reg;
            end
            if (cmd.report) begin
                out_valid_reg  <= 1'b1;
                any_reg        <= 1'b0;
                best_reg       <= '1;
                best_owner_reg <= '0;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.report) begin
            out_reg.hit_found        <= any_reg;
            out_reg.nearest_owner    <= any_reg ? best_owner_reg : '0;
            out_reg.nearest_distance <= best_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;
    assign status.last     = last_reg;
    assign status.hit      = hit_reg;
    assign status.out_busy = out_valid_reg && !m_ready;

endmodule

// ===== design/ray_triangle_nearest_hit_unit.sv =====
`timescale 1ns / 1ps

// Nearest-hit picker for one configured ray against a stream of triangles. Each triangle
// transfer is tested exactly in wide integer arithmetic; the transfer flagged last_triangle
// produces one result with the nearest hit, and the search then restarts. The block works on
// one triangle at a time: each is put through the shared digit-serial multiply-accumulate unit
// that forms the 24 products at 16 bits a cycle, and a hit also through the one-bit-a-cycle
// restoring divider. The triangle flagged last then passes through a report state that hands
// its result to the output register. A result waiting in the output register does not stop the
// next triangle being taken in, but the next last triangle waits until that result has been
// transferred.
module ray_triangle_nearest_hit_unit import rtnh_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tri_t                   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pick_t                  m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    rtnh_cmd_t    cmd;
    rtnh_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    rtnh_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rtnh_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
